// File: sv/nfz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfz_pkg: shared types and codes for the no-fly zone path check
// Verdict codes, register indexes and the per-item control struct that
// travels down the pipeline next to the arithmetic.
// ----------------------------------------------------------------------------
package nfz_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LON_A  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAT_B  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LON_B  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

	// verdict codes
	localparam int VERDICT_W = 3;
	localparam logic [VERDICT_W-1:0] VERDICT_SKIP  = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_SRC   = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_DST   = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_CROSS = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_CLEAR = 3'd4;

	localparam int NUM_SIDES = 4;

	// per-item decisions made up front; side_hit[i] is the zone-edge half of
	// the crossing test for edge i (path endpoints strictly on both sides)
	typedef struct packed {
		logic                 skip;
		logic                 src_in;
		logic                 dst_in;
		logic [NUM_SIDES-1:0] side_hit;
	} nfz_ctl_t;

endpackage
`default_nettype wire

// File: sv/nfz_prep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfz_prep: first pipeline stage
// Point-in-zone tests, zone-edge side tests and the coordinate differences
// that feed the cross-product multipliers.
// ----------------------------------------------------------------------------
module nfz_prep #(
	parameter int COORD_BITS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         ld,
	input  wire                         v_in,
	input  wire signed [COORD_BITS-2:0] src_lat,
	input  wire signed [COORD_BITS-1:0] src_lon,
	input  wire signed [COORD_BITS-2:0] dst_lat,
	input  wire signed [COORD_BITS-1:0] dst_lon,
	input  wire                         coords_wgs84,
	input  wire signed [COORD_BITS-2:0] lat_a,
	input  wire signed [COORD_BITS-1:0] lon_a,
	input  wire signed [COORD_BITS-2:0] lat_b,
	input  wire signed [COORD_BITS-1:0] lon_b,
	input  wire                         enabled,
	output logic                        v_s1,
	output nfz_pkg::nfz_ctl_t           ctl_s1,
	output logic signed [COORD_BITS:0]  px_s1,
	output logic signed [COORD_BITS-1:0] py_s1,
	output logic signed [COORD_BITS-1:0] dla_s1,
	output logic signed [COORD_BITS-1:0] dlb_s1,
	output logic signed [COORD_BITS:0]  doa_s1,
	output logic signed [COORD_BITS:0]  dob_s1
);
	import nfz_pkg::*;

	localparam int DIFF_W = COORD_BITS + 1;

	logic signed [COORD_BITS:0]   px_d, doa_d, dob_d;
	logic signed [COORD_BITS-1:0] py_d, dla_d, dlb_d;
	nfz_ctl_t                     ctl_d;

	// path vector and corner offsets from the source
	assign px_d  = DIFF_W'(dst_lon) - DIFF_W'(src_lon);
	assign py_d  = COORD_BITS'(dst_lat) - COORD_BITS'(src_lat);
	assign dla_d = COORD_BITS'(lat_a) - COORD_BITS'(src_lat);
	assign dlb_d = COORD_BITS'(lat_b) - COORD_BITS'(src_lat);
	assign doa_d = DIFF_W'(lon_a) - DIFF_W'(src_lon);
	assign dob_d = DIFF_W'(lon_b) - DIFF_W'(src_lon);

	always_comb begin
		ctl_d.skip   = !enabled || !coords_wgs84;
		ctl_d.src_in = ((src_lat < lat_a) != (src_lat < lat_b)) &&
			((src_lon < lon_a) != (src_lon < lon_b));
		ctl_d.dst_in = ((dst_lat < lat_a) != (dst_lat < lat_b)) &&
			((dst_lon < lon_a) != (dst_lon < lon_b));
		// axis-aligned edges: endpoints strictly on opposite sides of the line
		ctl_d.side_hit[0] = (lon_b != lon_a) &&
			(((src_lat < lat_a) && (dst_lat > lat_a)) ||
			((src_lat > lat_a) && (dst_lat < lat_a)));
		ctl_d.side_hit[1] = (lat_b != lat_a) &&
			(((src_lon < lon_b) && (dst_lon > lon_b)) ||
			((src_lon > lon_b) && (dst_lon < lon_b)));
		ctl_d.side_hit[2] = (lon_b != lon_a) &&
			(((src_lat < lat_b) && (dst_lat > lat_b)) ||
			((src_lat > lat_b) && (dst_lat < lat_b)));
		ctl_d.side_hit[3] = (lat_b != lat_a) &&
			(((src_lon < lon_a) && (dst_lon > lon_a)) ||
			((src_lon > lon_a) && (dst_lon < lon_a)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s1 <= ctl_d;
			px_s1  <= px_d;
			py_s1  <= py_d;
			dla_s1 <= dla_d;
			dlb_s1 <= dlb_d;
			doa_s1 <= doa_d;
			dob_s1 <= dob_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/nfz_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfz_mul: second pipeline stage
// The four partial products of the corner cross products against the path.
// ----------------------------------------------------------------------------
module nfz_mul #(
	parameter int COORD_BITS = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           ld,
	input  wire                           v_in,
	input  nfz_pkg::nfz_ctl_t             ctl_in,
	input  wire signed [COORD_BITS:0]     px,
	input  wire signed [COORD_BITS-1:0]   py,
	input  wire signed [COORD_BITS-1:0]   dla,
	input  wire signed [COORD_BITS-1:0]   dlb,
	input  wire signed [COORD_BITS:0]     doa,
	input  wire signed [COORD_BITS:0]     dob,
	output logic                          v_s2,
	output nfz_pkg::nfz_ctl_t             ctl_s2,
	output logic signed [2*COORD_BITS:0]  m0_s2,
	output logic signed [2*COORD_BITS:0]  m1_s2,
	output logic signed [2*COORD_BITS:0]  m2_s2,
	output logic signed [2*COORD_BITS:0]  m3_s2
);
	import nfz_pkg::*;

	localparam int PROD_W = 2 * COORD_BITS + 1;

	logic signed [PROD_W-1:0] m0_d, m1_d, m2_d, m3_d;

	assign m0_d = PROD_W'(px) * PROD_W'(dla);
	assign m1_d = PROD_W'(px) * PROD_W'(dlb);
	assign m2_d = PROD_W'(py) * PROD_W'(doa);
	assign m3_d = PROD_W'(py) * PROD_W'(dob);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld) begin
			v_s2 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s2 <= ctl_in;
			m0_s2  <= m0_d;
			m1_s2  <= m1_d;
			m2_s2  <= m2_d;
			m3_s2  <= m3_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/nfz_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfz_decide: third pipeline stage and verdict select
// Forms the corner cross products, registers their signs, then combines the
// sign changes with the edge side tests into the verdict.
// ----------------------------------------------------------------------------
module nfz_decide #(
	parameter int COORD_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          ld,
	input  wire                          v_in,
	input  nfz_pkg::nfz_ctl_t            ctl_in,
	input  wire signed [2*COORD_BITS:0]  m0,
	input  wire signed [2*COORD_BITS:0]  m1,
	input  wire signed [2*COORD_BITS:0]  m2,
	input  wire signed [2*COORD_BITS:0]  m3,
	output logic                         v_s3,
	output logic [nfz_pkg::VERDICT_W-1:0] verdict_d
);
	import nfz_pkg::*;

	localparam int CRS_W = 2 * COORD_BITS + 2;

	logic signed [CRS_W-1:0] crs [NUM_SIDES];
	logic [NUM_SIDES-1:0]    pos_d, neg_d;
	logic [NUM_SIDES-1:0]    pos_s3, neg_s3;
	nfz_ctl_t                ctl_s3;
	logic [NUM_SIDES-1:0]    flip;
	logic                    crossed;

	// corner k cross path: px*(cy_k - slat) - py*(cx_k - slon)
	assign crs[0] = CRS_W'(m0) - CRS_W'(m2);
	assign crs[1] = CRS_W'(m0) - CRS_W'(m3);
	assign crs[2] = CRS_W'(m1) - CRS_W'(m3);
	assign crs[3] = CRS_W'(m1) - CRS_W'(m2);

	always_comb begin
		for (int k = 0; k < NUM_SIDES; k++) begin
			neg_d[k] = crs[k][CRS_W-1];
			pos_d[k] = !crs[k][CRS_W-1] && (crs[k] != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld) begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s3 <= ctl_in;
			pos_s3 <= pos_d;
			neg_s3 <= neg_d;
		end
	end

	// edge i runs from corner i to corner i+1 (mod 4)
	always_comb begin
		for (int i = 0; i < NUM_SIDES; i++) begin
			flip[i] = (pos_s3[i] && neg_s3[(i + 1) % NUM_SIDES]) ||
				(neg_s3[i] && pos_s3[(i + 1) % NUM_SIDES]);
		end
	end

	assign crossed = |(flip & ctl_s3.side_hit);

	always_comb begin
		if (ctl_s3.skip) begin
			verdict_d = VERDICT_SKIP;
		end else if (ctl_s3.src_in) begin
			verdict_d = VERDICT_SRC;
		end else if (ctl_s3.dst_in) begin
			verdict_d = VERDICT_DST;
		end else if (crossed) begin
			verdict_d = VERDICT_CROSS;
		end else begin
			verdict_d = VERDICT_CLEAR;
		end
	end

endmodule
`default_nettype wire

// File: sv/nofly_zone_path_check.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: registers s1, s2, s3 and the output register in that order, s1
// loaded at the accepting edge; a query's verdict is presented from the
// output register once it has passed through s2 and s3.
// Throughput: one transaction per cycle unless the output stalls; bubbles
// are filled, so intake goes on while a result waits until all stages are full.
// Reset: arst_n clears all valid bits and zone registers (zone disabled).
// ----------------------------------------------------------------------------
// nofly_zone_path_check: segment against rectangular no-fly zone
// Verdict per query: not checked, source inside, destination inside, path
// crosses a zone edge, or clear. Exact integer cross products, pipelined.
// ----------------------------------------------------------------------------
module nofly_zone_path_check #(
	parameter int COORD_BITS = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// configuration write channel
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [nfz_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [COORD_BITS-1:0]              cfg_data,
	// query channel
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire signed [COORD_BITS-2:0]       src_lat,
	input  wire signed [COORD_BITS-1:0]       src_lon,
	input  wire signed [COORD_BITS-2:0]       dst_lat,
	input  wire signed [COORD_BITS-1:0]       dst_lon,
	input  wire                               coords_wgs84,
	// verdict channel
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [nfz_pkg::VERDICT_W-1:0]     verdict
);
	import nfz_pkg::*;

	localparam int LAT_W  = COORD_BITS - 1;
	localparam int LON_W  = COORD_BITS;
	localparam int PROD_W = 2 * COORD_BITS + 1;

	// zone registers
	logic signed [LAT_W-1:0] lat_a_q, lat_b_q;
	logic signed [LON_W-1:0] lon_a_q, lon_b_q;
	logic                    enabled_q;

	// pipeline load enables, one per register stage
	logic ld1, ld2, ld3, ld_out;

	// stage 1 outputs
	logic                    v_s1;
	nfz_ctl_t                ctl_s1;
	logic signed [LON_W:0]   px_s1, doa_s1, dob_s1;
	logic signed [LAT_W:0]   py_s1, dla_s1, dlb_s1;

	// stage 2 outputs
	logic                    v_s2;
	nfz_ctl_t                ctl_s2;
	logic signed [PROD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2;

	// stage 3 outputs
	logic                    v_s3;
	logic [VERDICT_W-1:0]    verdict_d;

	// output register
	logic                    out_valid_q;
	logic [VERDICT_W-1:0]    verdict_q;

	// ------------------------------------------------------------------
	// Configuration: always ready, a write lands at the handshake edge.
	// Indexes past the enable register are dropped.
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_a_q   <= '0;
			lon_a_q   <= '0;
			lat_b_q   <= '0;
			lon_b_q   <= '0;
			enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LAT_A: begin
					lat_a_q <= cfg_data[LAT_W-1:0];
				end
				REG_LON_A: begin
					lon_a_q <= cfg_data[LON_W-1:0];
				end
				REG_LAT_B: begin
					lat_b_q <= cfg_data[LAT_W-1:0];
				end
				REG_LON_B: begin
					lon_b_q <= cfg_data[LON_W-1:0];
				end
				REG_ENABLE: begin
					enabled_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stall chain: a stage loads when it is empty or its content moves on.
	// Bubbles are squeezed out, so a stalled output does not block intake
	// until every stage holds a live item.
	// ------------------------------------------------------------------
	assign ld_out   = !out_valid_q || !out_stall;
	assign ld3      = !v_s3 || ld_out;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_stall = !ld1;

	// stage 1: inside tests, edge side tests, coordinate differences
	nfz_prep #(
		.COORD_BITS(COORD_BITS)
	) u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.ld          (ld1),
		.v_in        (in_valid),
		.src_lat     (src_lat),
		.src_lon     (src_lon),
		.dst_lat     (dst_lat),
		.dst_lon     (dst_lon),
		.coords_wgs84(coords_wgs84),
		.lat_a       (lat_a_q),
		.lon_a       (lon_a_q),
		.lat_b       (lat_b_q),
		.lon_b       (lon_b_q),
		.enabled     (enabled_q),
		.v_s1        (v_s1),
		.ctl_s1      (ctl_s1),
		.px_s1       (px_s1),
		.py_s1       (py_s1),
		.dla_s1      (dla_s1),
		.dlb_s1      (dlb_s1),
		.doa_s1      (doa_s1),
		.dob_s1      (dob_s1)
	);

	// stage 2: four multipliers, each shared by two corner cross products
	nfz_mul #(
		.COORD_BITS(COORD_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.ld    (ld2),
		.v_in  (v_s1),
		.ctl_in(ctl_s1),
		.px    (px_s1),
		.py    (py_s1),
		.dla   (dla_s1),
		.dlb   (dlb_s1),
		.doa   (doa_s1),
		.dob   (dob_s1),
		.v_s2  (v_s2),
		.ctl_s2(ctl_s2),
		.m0_s2 (m0_s2),
		.m1_s2 (m1_s2),
		.m2_s2 (m2_s2),
		.m3_s2 (m3_s2)
	);

	// stage 3: cross product signs, then verdict priority select
	nfz_decide #(
		.COORD_BITS(COORD_BITS)
	) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld3),
		.v_in     (v_s2),
		.ctl_in   (ctl_s2),
		.m0       (m0_s2),
		.m1       (m1_s2),
		.m2       (m2_s2),
		.m3       (m3_s2),
		.v_s3     (v_s3),
		.verdict_d(verdict_d)
	);

	// output register: holds the verdict while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			verdict_q <= verdict_d;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

endmodule
`default_nettype wire

// File: sv/nfz_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nfz_checker: port-level checks for the no-fly zone path check
// Watches the handshakes and the verdict code; bound to the top level.
// ----------------------------------------------------------------------------
module nfz_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           cfg_ready,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire [nfz_pkg::VERDICT_W-1:0]  verdict
);
	import nfz_pkg::*;

	// a stalled verdict stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict))
		else $error("stalled verdict changed or dropped");

	// only defined verdict codes leave the block
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_SKIP) || (verdict == VERDICT_SRC) ||
			(verdict == VERDICT_DST) || (verdict == VERDICT_CROSS) ||
			(verdict == VERDICT_CLEAR))
		else $error("undefined verdict code");

	// an empty output register means the pipeline can always advance
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("intake stalled with empty output");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind nofly_zone_path_check nfz_checker u_nfz_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_ready(cfg_ready),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.verdict  (verdict)
);
`default_nettype wire

// File: sim/nofly_zone_path_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nofly_zone_path_check_tb: path-versus-zone verdict check
// Sends path queries under several zone settings and compares each verdict
// with an exact integer model of the rectangle tests, with random idling and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module nofly_zone_path_check_tb;
	import nfz_pkg::*;

	localparam int COORD_BITS = 32;
	localparam int LAT_W = COORD_BITS - 1;
	localparam int LON_W = COORD_BITS;
	localparam longint LAT_MIN = -(longint'(1) << (LAT_W - 1));
	localparam longint LAT_MAX = (longint'(1) << (LAT_W - 1)) - 1;
	localparam longint LON_MIN = -(longint'(1) << (LON_W - 1));
	localparam longint LON_MAX = (longint'(1) << (LON_W - 1)) - 1;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 33;
	localparam int ITEMS_PER_PHASE = 90;
	localparam int NUM_PHASES = 9;
	localparam int HOLD_CYCLES = 150;
	localparam int REPORT_MAX = 10;
	localparam int REG_SPARE_FIRST = REG_ENABLE + 1;

	// reference zone, corners a = (lat 37.0, lon 126.8), b = (lat 37.5, lon 127.2)
	localparam longint Z1_LAT_A = 370000000;
	localparam longint Z1_LON_A = 1268000000;
	localparam longint Z1_LAT_B = 375000000;
	localparam longint Z1_LON_B = 1272000000;

	typedef struct {
		logic signed [LAT_W-1:0] src_lat;
		logic signed [LON_W-1:0] src_lon;
		logic signed [LAT_W-1:0] dst_lat;
		logic signed [LON_W-1:0] dst_lon;
		logic                    wgs84;
	} query_t;

	// Holds its own copy of the zone registers and the verdicts still owed.
	class verdict_scoreboard;
		longint zone_lat_a, zone_lon_a, zone_lat_b, zone_lon_b;
		bit zone_on;
		logic [VERDICT_W-1:0] verdicts_due[$];
		int errors, checked;
		int seen[VERDICT_CLEAR + 1];

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
			logic signed [LAT_W-1:0] lat_v;
			logic signed [LON_W-1:0] lon_v;
			lat_v = data[LAT_W-1:0];
			lon_v = data[LON_W-1:0];
			case (idx)
				REG_LAT_A:  zone_lat_a = longint'(lat_v);
				REG_LON_A:  zone_lon_a = longint'(lon_v);
				REG_LAT_B:  zone_lat_b = longint'(lat_v);
				REG_LON_B:  zone_lon_b = longint'(lon_v);
				REG_ENABLE: zone_on = data[0];
				default: ;
			endcase
		endfunction

		// sign of ax*by - ay*bx, products kept exact at 128 bits
		function int cross_sign(longint ax, longint ay, longint bx, longint by);
			logic signed [127:0] wax, way, wbx, wby, d;
			wax = 128'(ax);
			way = 128'(ay);
			wbx = 128'(bx);
			wby = 128'(by);
			d = wax * wby - way * wbx;
			if (d < 0)
				return -1;
			if (d == 0)
				return 0;
			return 1;
		endfunction

		function bit opposite(int a, int b);
			return (a > 0 && b < 0) || (a < 0 && b > 0);
		endfunction

		// the lower edge on each axis counts as inside, the upper edge does not
		function bit inside_zone(longint lat, longint lon);
			return ((lat < zone_lat_a) != (lat < zone_lat_b)) &&
				((lon < zone_lon_a) != (lon < zone_lon_b));
		endfunction

		function logic [VERDICT_W-1:0] predict_verdict(query_t q);
			longint slat, slon, dlat, dlon, px, py, ex, ey;
			longint cx[NUM_SIDES], cy[NUM_SIDES];
			int s1, s2, s3, s4, j;
			bit crossed;
			slat = longint'(q.src_lat);
			slon = longint'(q.src_lon);
			dlat = longint'(q.dst_lat);
			dlon = longint'(q.dst_lon);
			if (!zone_on || !q.wgs84)
				return VERDICT_SKIP;
			if (inside_zone(slat, slon))
				return VERDICT_SRC;
			if (inside_zone(dlat, dlon))
				return VERDICT_DST;
			cx = '{zone_lon_a, zone_lon_b, zone_lon_b, zone_lon_a};
			cy = '{zone_lat_a, zone_lat_a, zone_lat_b, zone_lat_b};
			px = dlon - slon;
			py = dlat - slat;
			crossed = 1'b0;
			for (int i = 0; i < NUM_SIDES; i++) begin
				j = (i + 1) % NUM_SIDES;
				ex = cx[j] - cx[i];
				ey = cy[j] - cy[i];
				s1 = cross_sign(px, py, cx[i] - slon, cy[i] - slat);
				s2 = cross_sign(px, py, cx[j] - slon, cy[j] - slat);
				s3 = cross_sign(ex, ey, slon - cx[i], slat - cy[i]);
				s4 = cross_sign(ex, ey, dlon - cx[i], dlat - cy[i]);
				if (opposite(s1, s2) && opposite(s3, s4))
					crossed = 1'b1;
			end
			return crossed ? VERDICT_CROSS : VERDICT_CLEAR;
		endfunction

		function void note_query(query_t q);
			verdicts_due.push_back(predict_verdict(q));
		endfunction

		function void check_verdict(logic [VERDICT_W-1:0] got);
			logic [VERDICT_W-1:0] want;
			if (verdicts_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("ERROR: verdict %0d arrived with none outstanding", got);
				return;
			end
			want = verdicts_due.pop_front();
			checked++;
			seen[want]++;
			if (got !== want) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("ERROR: verdict #%0d expected %0d, got %0d", checked, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COORD_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [LAT_W-1:0] src_lat = '0;
	logic signed [LON_W-1:0] src_lon = '0;
	logic signed [LAT_W-1:0] dst_lat = '0;
	logic signed [LON_W-1:0] dst_lon = '0;
	logic coords_wgs84 = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VERDICT_W-1:0] verdict;

	verdict_scoreboard sb = new;

	bit calm = 1'b0;       // no idling on either side while set
	bit hold_req = 1'b0;   // asks the receiver for one long hold-off
	int hold_left = 0;
	int zones_set = 0;
	int blocked_cycles = 0;
	int cycle_count = 0;

	nofly_zone_path_check #(
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.src_lat(src_lat),
		.src_lon(src_lon),
		.dst_lat(dst_lat),
		.dst_lon(dst_lon),
		.coords_wgs84(coords_wgs84),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.verdict(verdict)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: everything is sampled right after the edge, so it sees the
	// values that the block saw at that edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_query('{src_lat, src_lon, dst_lat, dst_lon, coords_wgs84});
		if (in_valid && in_stall)
			blocked_cycles++;
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_index, cfg_data);
	end

	// Verdict receiver: random stall, plus one long hold-off on request so the
	// pipeline fills and pushes back on the query channel.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_verdict(verdict);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: run still busy after %0d cycles, %0d verdicts outstanding",
			CYCLE_LIMIT, sb.verdicts_due.size());
		$display("Mismatches found");
		$finish;
	end

	// Leaves cfg_valid high on return; the caller lowers it after a group.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Latitude writes carry a random bit above the field to show it is dropped.
	task automatic set_zone(longint la, longint oa, longint lb, longint ob,
			logic [COORD_BITS-1:0] en_word);
		write_reg(REG_LAT_A, {1'($urandom_range(1)), la[LAT_W-1:0]});
		write_reg(REG_LON_A, oa[LON_W-1:0]);
		write_reg(REG_LAT_B, {1'($urandom_range(1)), lb[LAT_W-1:0]});
		write_reg(REG_LON_B, ob[LON_W-1:0]);
		write_reg(REG_ENABLE, en_word);
		cfg_valid <= 1'b0;
		zones_set++;
	endtask

	task automatic send_query(query_t q);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		src_lat <= q.src_lat;
		src_lon <= q.src_lon;
		dst_lat <= q.dst_lat;
		dst_lon <= q.dst_lon;
		coords_wgs84 <= q.wgs84;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering and wait until every verdict owed has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic query_t directed_query(longint sla, longint slo, longint dla,
			longint dlo, bit w);
		query_t q;
		q.src_lat = LAT_W'(sla);
		q.src_lon = LON_W'(slo);
		q.dst_lat = LAT_W'(dla);
		q.dst_lon = LON_W'(dlo);
		q.wgs84 = w;
		return q;
	endfunction

	// Coordinate around [lo, hi]: often exactly on a bound or one off it,
	// otherwise anywhere in a window twice the zone width, clipped to the field.
	function automatic longint pick_coord(longint lo, longint hi, int width);
		longint span, lim_lo, lim_hi, v;
		longint unsigned r;
		span = (hi - lo) / 2 + 64;
		lim_lo = -(longint'(1) << (width - 1));
		lim_hi = (longint'(1) << (width - 1)) - 1;
		r = {$urandom(), $urandom()};
		case ($urandom_range(7))
			0: v = lo;
			1: v = hi;
			2: v = lo + longint'($urandom_range(2)) - 1;
			3: v = hi + longint'($urandom_range(2)) - 1;
			default: v = lo - span + longint'(r % longint'(hi - lo + 2 * span + 1));
		endcase
		if (v < lim_lo)
			v = lim_lo;
		if (v > lim_hi)
			v = lim_hi;
		return v;
	endfunction

	// Mostly paths aimed at the current zone; one in ten is raw bit noise so
	// every field bit toggles, and one in ten is a point path.
	function automatic query_t random_query();
		query_t q;
		longint lat_lo, lat_hi, lon_lo, lon_hi;
		lat_lo = (sb.zone_lat_a < sb.zone_lat_b) ? sb.zone_lat_a : sb.zone_lat_b;
		lat_hi = (sb.zone_lat_a < sb.zone_lat_b) ? sb.zone_lat_b : sb.zone_lat_a;
		lon_lo = (sb.zone_lon_a < sb.zone_lon_b) ? sb.zone_lon_a : sb.zone_lon_b;
		lon_hi = (sb.zone_lon_a < sb.zone_lon_b) ? sb.zone_lon_b : sb.zone_lon_a;
		if ($urandom_range(9) == 0) begin
			q.src_lat = LAT_W'($urandom());
			q.src_lon = LON_W'($urandom());
			q.dst_lat = LAT_W'($urandom());
			q.dst_lon = LON_W'($urandom());
		end else begin
			q.src_lat = LAT_W'(pick_coord(lat_lo, lat_hi, LAT_W));
			q.src_lon = LON_W'(pick_coord(lon_lo, lon_hi, LON_W));
			q.dst_lat = LAT_W'(pick_coord(lat_lo, lat_hi, LAT_W));
			q.dst_lon = LON_W'(pick_coord(lon_lo, lon_hi, LON_W));
		end
		if ($urandom_range(9) == 0) begin
			q.dst_lat = q.src_lat;
			q.dst_lon = q.src_lon;
		end
		q.wgs84 = ($urandom_range(9) != 0);
		return q;
	endfunction

	initial begin
		longint la, oa, lb, ob;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zone disabled out of reset: everything comes back unchecked.
		send_query(directed_query(372000000, 1270000000, 380000000, 1270000000, 1'b1));
		send_query(directed_query(0, 0, 0, 0, 1'b1));
		send_query(directed_query(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX, 1'b1));
		drain();

		// Spare register indexes must not disturb the zone.
		for (int i = REG_SPARE_FIRST; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), $urandom());
		set_zone(Z1_LAT_A, Z1_LON_A, Z1_LAT_B, Z1_LON_B, 32'h1);

		// Directed paths against the reference zone
		send_query(directed_query(372000000, 1270000000, 380000000, 1270000000, 1'b1));
		send_query(directed_query(360000000, 1270000000, 372000000, 1270000000, 1'b1));
		send_query(directed_query(360000000, 1270000000, 380000000, 1270000000, 1'b1));
		send_query(directed_query(372000000, 1260000000, 372000000, 1280000000, 1'b1));
		send_query(directed_query(360000000, 1260000000, 380000000, 1260000000, 1'b1));
		// not WGS84: no test made even with the source inside
		send_query(directed_query(372000000, 1270000000, 380000000, 1270000000, 1'b0));
		// a-side corner is inside, b-side corner is not
		send_query(directed_query(Z1_LAT_A, Z1_LON_A, 380000000, 1280000000, 1'b1));
		send_query(directed_query(Z1_LAT_B, Z1_LON_B, 380000000, 1280000000, 1'b1));
		// running along an edge touches but never crosses
		send_query(directed_query(Z1_LAT_A, 1260000000, Z1_LAT_A, 1280000000, 1'b1));
		send_query(directed_query(Z1_LAT_B, 1260000000, Z1_LAT_B, 1280000000, 1'b1));
		send_query(directed_query(365000000, 1266000000, 380000000, 1276000000, 1'b1));
		// point paths, outside and inside
		send_query(directed_query(360000000, 1260000000, 360000000, 1260000000, 1'b1));
		send_query(directed_query(372000000, 1270000000, 372000000, 1270000000, 1'b1));
		// field extremes and the legal range ends
		send_query(directed_query(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX, 1'b1));
		send_query(directed_query(LAT_MAX, LON_MAX, LAT_MIN, LON_MIN, 1'b1));
		send_query(directed_query(-900000000, -1800000000, 900000000, 1800000000, 1'b1));
		send_query(directed_query(0, 0, -1, -1, 1'b1));
		send_query(directed_query(LAT_MIN, LON_MAX, LAT_MAX, LON_MIN, 1'b0));

		// Random phases, one zone setting each, drained before every rewrite.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			calm = 1'b0;
			case (p)
				0: set_zone(Z1_LAT_A, Z1_LON_A, Z1_LAT_B, Z1_LON_B, 32'h1);
				1: set_zone(-100000000, 500000000, -300000000, -200000000, 32'h1);
				2: begin
					// stretch with no idling on either side
					calm = 1'b1;
					la = longint'($urandom_range(1800000000)) - 900000000;
					lb = longint'($urandom_range(1800000000)) - 900000000;
					oa = longint'($urandom_range(32'd3600000000)) - 1800000000;
					ob = longint'($urandom_range(32'd3600000000)) - 1800000000;
					set_zone(la, oa, lb, ob, 32'h1);
				end
				3: set_zone(LAT_MIN, LON_MIN, LAT_MAX, LON_MAX, 32'h1);
				4: set_zone(900000000, 1800000000, -900000000, -1800000000, 32'h1);
				// equal latitudes: nothing is inside, edges can still be crossed
				5: set_zone(12345678, -50000000, 12345678, 50000000, 32'h1);
				6: set_zone(0, 0, 1, 1, 32'h1);
				// enable bit clear with the upper bits set
				7: set_zone(Z1_LAT_A, Z1_LON_A, Z1_LAT_B, Z1_LON_B, 32'hFFFF_FFFE);
				default: begin
					la = longint'($urandom_range(1800000000)) - 900000000;
					lb = la + longint'($urandom_range(2000000));
					oa = longint'($urandom_range(32'd3600000000)) - 1800000000;
					ob = oa - longint'($urandom_range(2000000));
					set_zone(la, oa, lb, ob, 32'h3);
				end
			endcase
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (p == 0 && k == 20)
					hold_req = 1'b1;
				send_query(random_query());
			end
		end

		drain();
		calm = 1'b0;
		// let the clock run on to catch any stray verdict
		repeat (10) @(posedge clk);
		if (sb.verdicts_due.size() != 0)
			sb.errors++;

		$display("Checked %0d verdicts over %0d zone settings:", sb.checked, zones_set);
		$display("  unchecked %0d, source %0d, dest %0d, cross %0d, clear %0d",
			sb.seen[VERDICT_SKIP], sb.seen[VERDICT_SRC], sb.seen[VERDICT_DST],
			sb.seen[VERDICT_CROSS], sb.seen[VERDICT_CLEAR]);
		$display("Query channel held off for %0d cycles; verdict errors: %0d",
			blocked_cycles, sb.errors);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
